/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) p) else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, c, p) \
  lbl: assert property (@(posedge c) p) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, c, r, p)
`define ASSERT_ALWAYS(lbl, c, p)
`endif
`endif

/* rtl/core/i64alu_pkg.sv */
`timescale 1ns / 1ps
package i64alu_pkg;
  localparam int DW = 64;
  localparam int FW = 5;
  localparam int NCELL = 64;

  localparam logic [FW-1:0] F_ADD = 5'd0;
  localparam logic [FW-1:0] F_SUB = 5'd1;
  localparam logic [FW-1:0] F_MUL = 5'd2;
  localparam logic [FW-1:0] F_DIV = 5'd3;
  localparam logic [FW-1:0] F_MOD = 5'd4;
  localparam logic [FW-1:0] F_AND = 5'd5;
  localparam logic [FW-1:0] F_OR  = 5'd6;
  localparam logic [FW-1:0] F_XOR = 5'd7;
  localparam logic [FW-1:0] F_NOT = 5'd8;
  localparam logic [FW-1:0] F_SHL = 5'd9;
  localparam logic [FW-1:0] F_SAR = 5'd10;
  localparam logic [FW-1:0] F_SHR = 5'd11;
  localparam logic [FW-1:0] F_NEG = 5'd12;
  localparam logic [FW-1:0] F_LT  = 5'd13;
  localparam logic [FW-1:0] F_LE  = 5'd14;
  localparam logic [FW-1:0] F_GT  = 5'd15;
  localparam logic [FW-1:0] F_GE  = 5'd16;
  localparam logic [FW-1:0] F_EQ  = 5'd17;
  localparam logic [FW-1:0] F_NE  = 5'd18;

  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_DIV0  = 2'd1;
  localparam logic [1:0] E_SHIFT = 2'd2;

  typedef struct packed {
    logic [FW-1:0] func;
    logic [DW-1:0] res;   // result of ops computed in i64alu_pre
    logic [1:0]    err;
    logic          qneg;
    logic          rneg;
    logic [DW-1:0] acc;   // multiply accumulator
    logic [DW-1:0] ma;    // shifted multiplicand
    logic [DW-1:0] mb;    // shifted multiplier
    logic [DW-1:0] n;     // dividend bits out, quotient bits in
    logic [DW-1:0] d;     // divisor magnitude
    logic [DW-1:0] r;     // partial remainder
  } cell_t;
endpackage

/* rtl/core/i64alu_pre.sv */
`timescale 1ns / 1ps
module i64alu_pre (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [i64alu_pkg::FW-1:0]     func,
  input  logic signed [i64alu_pkg::DW-1:0] operand_a,
  input  logic signed [i64alu_pkg::DW-1:0] operand_b,
  output logic                          out_vld,
  output i64alu_pkg::cell_t             out_c
);
  i64alu_pkg::cell_t c_next;
  logic [i64alu_pkg::DW-1:0] a_mag;
  logic [i64alu_pkg::DW-1:0] b_mag;
  logic                      bad_sh;
  logic [5:0]                sh;
  logic                      lt;
  logic                      gt;
  logic                      eq;

  always_comb begin
    a_mag  = operand_a[63] ? (64'd0 - operand_a) : operand_a;
    b_mag  = operand_b[63] ? (64'd0 - operand_b) : operand_b;
    bad_sh = operand_b[63] | (|operand_b[62:6]);
    sh     = operand_b[5:0];
    lt     = operand_a < operand_b;
    gt     = operand_b < operand_a;
    eq     = operand_a == operand_b;
    c_next      = '0;
    c_next.func = func;
    c_next.qneg = operand_a[63] ^ operand_b[63];
    c_next.rneg = operand_a[63];
    c_next.ma   = operand_a;
    c_next.mb   = operand_b;
    c_next.n    = a_mag;
    c_next.d    = b_mag;
    unique case (func)
      i64alu_pkg::F_ADD: c_next.res = operand_a + operand_b;
      i64alu_pkg::F_SUB: c_next.res = operand_a - operand_b;
      i64alu_pkg::F_DIV, i64alu_pkg::F_MOD: begin
        if (operand_b == '0) c_next.err = i64alu_pkg::E_DIV0;
      end
      i64alu_pkg::F_AND: c_next.res = operand_a & operand_b;
      i64alu_pkg::F_OR:  c_next.res = operand_a | operand_b;
      i64alu_pkg::F_XOR: c_next.res = operand_a ^ operand_b;
      i64alu_pkg::F_NOT: c_next.res = ~operand_a;
      i64alu_pkg::F_SHL: begin
        if (bad_sh) c_next.err = i64alu_pkg::E_SHIFT;
        else c_next.res = operand_a << sh;
      end
      i64alu_pkg::F_SAR: begin
        if (bad_sh) c_next.err = i64alu_pkg::E_SHIFT;
        else c_next.res = operand_a >>> sh;
      end
      i64alu_pkg::F_SHR: begin
        if (bad_sh) c_next.err = i64alu_pkg::E_SHIFT;
        else c_next.res = operand_a >> sh;
      end
      i64alu_pkg::F_NEG: c_next.res = 64'd0 - operand_a;
      i64alu_pkg::F_LT:  c_next.res = {63'd0, lt};
      i64alu_pkg::F_LE:  c_next.res = {63'd0, !gt};
      i64alu_pkg::F_GT:  c_next.res = {63'd0, gt};
      i64alu_pkg::F_GE:  c_next.res = {63'd0, !lt};
      i64alu_pkg::F_EQ:  c_next.res = {63'd0, eq};
      i64alu_pkg::F_NE:  c_next.res = {63'd0, !eq};
      default: c_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= c_next;
    end
  end
endmodule

/* rtl/core/i64alu_cell.sv */
`timescale 1ns / 1ps
// One multiply bit and one restoring divide bit per cell.
module i64alu_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  i64alu_pkg::cell_t in_c,
  output logic              out_vld,
  output i64alu_pkg::cell_t out_c
);
  i64alu_pkg::cell_t         c_next;
  logic [i64alu_pkg::DW-1:0] trial;
  logic [i64alu_pkg::DW:0]   diff;

  always_comb begin
    c_next     = in_c;
    c_next.acc = in_c.acc + (in_c.mb[0] ? in_c.ma : '0);
    c_next.ma  = {in_c.ma[i64alu_pkg::DW-2:0], 1'b0};
    c_next.mb  = {1'b0, in_c.mb[i64alu_pkg::DW-1:1]};
    trial      = {in_c.r[i64alu_pkg::DW-2:0], in_c.n[i64alu_pkg::DW-1]};
    diff       = {1'b0, trial} - {1'b0, in_c.d};
    if (!diff[i64alu_pkg::DW]) begin
      c_next.r = diff[i64alu_pkg::DW-1:0];
      c_next.n = {in_c.n[i64alu_pkg::DW-2:0], 1'b1};
    end else begin
      c_next.r = trial;
      c_next.n = {in_c.n[i64alu_pkg::DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= c_next;
    end
  end
endmodule

/* rtl/core/i64alu_post.sv */
`timescale 1ns / 1ps
module i64alu_post (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  i64alu_pkg::cell_t                 in_c,
  output logic                              out_vld,
  output logic signed [i64alu_pkg::DW-1:0]  result,
  output logic [1:0]                        error_code
);
  logic [i64alu_pkg::DW-1:0] res_next;

  always_comb begin
    if (in_c.err != i64alu_pkg::E_NONE) begin
      res_next = '0;
    end else begin
      unique case (in_c.func)
        i64alu_pkg::F_MUL: res_next = in_c.acc;
        i64alu_pkg::F_DIV: res_next = in_c.qneg ? (64'd0 - in_c.n) : in_c.n;
        i64alu_pkg::F_MOD: res_next = in_c.rneg ? (64'd0 - in_c.r) : in_c.r;
        default:           res_next = in_c.res;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result     <= res_next;
      error_code <= in_c.err;
    end
  end
endmodule

/* rtl/core/int64_wrapping_alu.sv */
`timescale 1ns / 1ps
// channel   | valid     | ready     | payload
// request   | req_valid | req_ready | func, operand_a, operand_b
// response  | res_valid | res_ready | result, error_code
//
// Stages: one decode stage, 64 cells (one multiply bit and one
// divide bit each), one output register. One request per cycle while the chain is not held.
// The whole chain advances together; it holds only while the output
// register is full and res_ready is low. Reset clears all valid bits.
`include "assert_macros.svh"
module int64_wrapping_alu (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [i64alu_pkg::FW-1:0]         func,
  input  logic signed [i64alu_pkg::DW-1:0]  operand_a,
  input  logic signed [i64alu_pkg::DW-1:0]  operand_b,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic signed [i64alu_pkg::DW-1:0]  result,
  output logic [1:0]                        error_code
);
  logic                en;
  logic                vld [0:i64alu_pkg::NCELL];
  i64alu_pkg::cell_t   chain [0:i64alu_pkg::NCELL];

  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  i64alu_pre u_pre (
    .clk(clk), .rst(rst), .en(en), .in_vld(req_valid && en),
    .func(func), .operand_a(operand_a), .operand_b(operand_b),
    .out_vld(vld[0]), .out_c(chain[0])
  );

  for (genvar i = 0; i < i64alu_pkg::NCELL; i++) begin : g_cell
    i64alu_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_vld(vld[i]), .in_c(chain[i]),
      .out_vld(vld[i+1]), .out_c(chain[i+1])
    );
  end

  i64alu_post u_post (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(vld[i64alu_pkg::NCELL]), .in_c(chain[i64alu_pkg::NCELL]),
    .out_vld(res_valid), .result(result), .error_code(error_code)
  );

  `ASSERT_RST(a_err_zero, clk, rst, res_valid && error_code != i64alu_pkg::E_NONE |-> result == '0)
  `ASSERT_RST(a_err_code, clk, rst, res_valid |-> (error_code <= i64alu_pkg::E_SHIFT))
  `ASSERT_RST(a_ready, clk, rst, req_ready == (!res_valid || res_ready))
  `ASSERT_RST(a_rst_clear, clk, rst, $past(rst) |-> !res_valid)
endmodule

/* verif/int64_wrapping_alu_test.sv */
`timescale 1ns / 1ps
module int64_wrapping_alu_test;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL1 = 64'hffff_ffff_ffff_ffff;
  localparam int LATENCY = 66;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  err;
  } alu_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [i64alu_pkg::FW-1:0] func = '0;
  logic signed [i64alu_pkg::DW-1:0] operand_a = '0;
  logic signed [i64alu_pkg::DW-1:0] operand_b = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic signed [i64alu_pkg::DW-1:0] result;
  logic [1:0] error_code;

  alu_out_t expected_q[$];
  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int idle_pct = 26;
  int hold_cycles = 0;
  longint cycle_count = 0;

  int64_wrapping_alu u_dut (.*);

  always #5 clk = ~clk;

  function automatic alu_out_t compute_alu(logic [i64alu_pkg::FW-1:0] f,
                                           logic [63:0] a, logic [63:0] b);
    alu_out_t o;
    logic signed [63:0] sa, sb;
    sa = a;
    sb = b;
    o = '0;
    case (f)
      i64alu_pkg::F_ADD: o.value = a + b;
      i64alu_pkg::F_SUB: o.value = a - b;
      i64alu_pkg::F_MUL: o.value = a * b;
      i64alu_pkg::F_DIV, i64alu_pkg::F_MOD: begin
        if (b == 0) begin
          o.err = i64alu_pkg::E_DIV0;
        end else if (a == MIN64 && b == ALL1) begin
          o.value = (f == i64alu_pkg::F_DIV) ? MIN64 : 64'd0;
        end else begin
          o.value = (f == i64alu_pkg::F_DIV) ? sa / sb : sa % sb;
        end
      end
      i64alu_pkg::F_AND: o.value = a & b;
      i64alu_pkg::F_OR: o.value = a | b;
      i64alu_pkg::F_XOR: o.value = a ^ b;
      i64alu_pkg::F_NOT: o.value = ~a;
      i64alu_pkg::F_SHL, i64alu_pkg::F_SAR, i64alu_pkg::F_SHR: begin
        if (b > 64'd63) begin
          o.err = i64alu_pkg::E_SHIFT;
        end else if (f == i64alu_pkg::F_SHL) begin
          o.value = a << b[5:0];
        end else if (f == i64alu_pkg::F_SAR) begin
          o.value = sa >>> b[5:0];
        end else begin
          o.value = a >> b[5:0];
        end
      end
      i64alu_pkg::F_NEG: o.value = 64'd0 - a;
      i64alu_pkg::F_LT: o.value = {63'd0, sa < sb};
      i64alu_pkg::F_LE: o.value = {63'd0, sa <= sb};
      i64alu_pkg::F_GT: o.value = {63'd0, sa > sb};
      i64alu_pkg::F_GE: o.value = {63'd0, sa >= sb};
      i64alu_pkg::F_EQ: o.value = {63'd0, a == b};
      i64alu_pkg::F_NE: o.value = {63'd0, a != b};
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = MIN64;
      1: v = MAX64;
      2: v = ALL1;
      3: v = 64'd0;
      4: v = 64'($urandom_range(0, 70));
      5: v = -$signed({32'd0, $urandom_range(0, 70)});
      6: v = 64'($signed(v[15:0]));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_request(logic [i64alu_pkg::FW-1:0] f, logic [63:0] a, logic [63:0] b);
    while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    func <= f;
    operand_a <= a;
    operand_b <= b;
    req_valid <= 1'b1;
    expected_q.push_back(compute_alu(f, a, b));
    sent_count++;
    do @(posedge clk); while (!req_ready);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= !(idle_pct > 0 && $urandom_range(1, 100) <= idle_pct);
    end
  end

  always @(posedge clk) begin
    alu_out_t exp_r;
    if (!rst && res_valid && res_ready) begin
      checked_count++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response result=%h err=%0d", $time, result, error_code);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (result !== exp_r.value) begin
          $display("%0t: result expected %h actual %h", $time, exp_r.value, result);
          fail_count++;
        end
        if (error_code !== exp_r.err) begin
          $display("%0t: error_code expected %0d actual %0d", $time, exp_r.err, error_code);
          fail_count++;
        end
      end
    end
  end

  task automatic test_edges();
    logic [63:0] vals[6];
    vals = '{MIN64, MAX64, ALL1, 64'd0, 64'd1, 64'd63};
    for (int f = 0; f <= 18; f++)
      send_request(f[i64alu_pkg::FW-1:0], vals[$urandom_range(0, 5)],
                   vals[$urandom_range(0, 5)]);
    send_request(i64alu_pkg::F_DIV, MIN64, ALL1);
    send_request(i64alu_pkg::F_MOD, MIN64, ALL1);
    send_request(i64alu_pkg::F_DIV, 64'd5, 64'd0);
    send_request(i64alu_pkg::F_SHL, 64'd1, 64'd64);
    send_request(i64alu_pkg::F_SAR, MIN64, ALL1);
    send_request(i64alu_pkg::F_NEG, MIN64, 64'd7);
    send_request(5'd31, MAX64, MAX64);
  endtask

  task automatic test_random(int n);
    logic [i64alu_pkg::FW-1:0] f;
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(0, 19) == 0) ? i64alu_pkg::FW'($urandom_range(19, 31))
                                       : i64alu_pkg::FW'($urandom_range(0, 18));
      send_request(f, rand64(), rand64());
    end
  endtask

  task automatic test_backpressure();
    hold_cycles <= 300;
    test_random(150);
  endtask

  task automatic test_full_rate();
    idle_pct = 0;
    test_random(400);
    idle_pct = 26;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_random(800);
    test_backpressure();
    test_full_rate();
    test_random(650);
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d requests (all ops, div/shift errors, unused selectors), checked %0d.",
             sent_count, checked_count);
    $display("Included a long output stall and a full-rate stretch with no idling.");
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* int64_wrapping_alu.f */
+incdir+rtl/core
rtl/core/i64alu_pkg.sv
rtl/core/i64alu_pre.sv
rtl/core/i64alu_cell.sv
rtl/core/i64alu_post.sv
rtl/core/int64_wrapping_alu.sv
verif/int64_wrapping_alu_test.sv
